// ----- hdl/plyuv_pkg.sv -----
package plyuv_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int DIM_W   = 13;
  localparam int MODE_W  = 3;
  localparam int ADDR_W  = 24;
  localparam int CADDR_W = 23;
  localparam int DEST_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int AREA_W  = 2 * DIM_W;
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT / 2);
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_HEIGHT = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_MODE   = IDX_W'(2);

  localparam logic [MODE_W-1:0] MODE_I420  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_NV12  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_NV21  = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_SPLIT = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_UVYY  = MODE_W'(4);

  localparam logic [DEST_W-1:0] DEST_SHARED = DEST_W'(0);
  localparam logic [DEST_W-1:0] DEST_U      = DEST_W'(1);
  localparam logic [DEST_W-1:0] DEST_V      = DEST_W'(2);

  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [XW-1:0]     half;
    logic [AREA_W-1:0] area;
    logic [MODE_W-1:0] mode;
  } geom_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  b2;
    logic [BYTE_W-1:0]  b1;
    logic [BYTE_W-1:0]  b0;
    logic [XW-1:0]      x;
    logic [ADDR_W-1:0]  wy;
    logic [CADDR_W-1:0] hy;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  upper_luma_addr;
    logic [BYTE_W-1:0]  upper_luma_data;
    logic [ADDR_W-1:0]  lower_luma_addr;
    logic [BYTE_W-1:0]  lower_luma_data;
    logic [DEST_W-1:0]  chroma_dest;
    logic [CADDR_W-1:0] chroma_addr;
    logic [BYTE_W-1:0]  chroma_data;
    logic               chroma_is_v;
    logic               frame_last;
  } res_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] t;
    t = v;
    if (t < DIM_W'(2)) t = DIM_W'(2);
    if (t > maxv) t = maxv;
    return {t[DIM_W-1:1], 1'b0};
  endfunction

endpackage

// ----- hdl/packed_luma_pair_to_planar_yuv.sv -----
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_src_word
// out     | output    | out_valid / out_ready | out_upper_luma_addr .. out_frame_last
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat per clock in and out unless out stalls; input register feeds result register.
// Input register holds the word and its position; address adders feed the result register.
// Synchronous active-low reset clears counters and valids; cfg registers go to defaults.
// A stall on out holds both stages; in_ready drops only when both stages are full.
// cfg_ready is always high; WIDTH/HEIGHT/MODE writes restart the frame at column 0, row 0.
module packed_luma_pair_to_planar_yuv (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [plyuv_pkg::WORD_W-1:0]       in_src_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [plyuv_pkg::ADDR_W-1:0]       out_upper_luma_addr,
  output logic [plyuv_pkg::BYTE_W-1:0]       out_upper_luma_data,
  output logic [plyuv_pkg::ADDR_W-1:0]       out_lower_luma_addr,
  output logic [plyuv_pkg::BYTE_W-1:0]       out_lower_luma_data,
  output logic [plyuv_pkg::DEST_W-1:0]       out_chroma_dest,
  output logic [plyuv_pkg::CADDR_W-1:0]      out_chroma_addr,
  output logic [plyuv_pkg::BYTE_W-1:0]       out_chroma_data,
  output logic                               out_chroma_is_v,
  output logic                               out_frame_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [plyuv_pkg::IDX_W-1:0]        cfg_index,
  input  logic [plyuv_pkg::DIM_W-1:0]        cfg_data
);

  logic [plyuv_pkg::DIM_W-1:0]   width_r;
  logic [plyuv_pkg::DIM_W-1:0]   height_r;
  logic [plyuv_pkg::MODE_W-1:0]  mode_r;
  logic [plyuv_pkg::AREA_W-1:0]  area_r;
  logic [plyuv_pkg::XW-1:0]      col_r;
  logic [plyuv_pkg::YW-1:0]      row_r;
  logic [plyuv_pkg::ADDR_W-1:0]  wy_r;
  logic [plyuv_pkg::CADDR_W-1:0] hy_r;
  logic                          s1_valid_r;
  logic                          out_valid_r;
  plyuv_pkg::item_t              s1_r;
  plyuv_pkg::item_t              s1_nxt;
  plyuv_pkg::res_t               out_r;
  plyuv_pkg::res_t               res;
  plyuv_pkg::geom_t              geom;

  logic [plyuv_pkg::DIM_W-1:0]   w_eff;
  logic [plyuv_pkg::DIM_W-1:0]   h_eff;
  logic [plyuv_pkg::XW-1:0]      col_max;
  logic [plyuv_pkg::YW-1:0]      row_max;
  logic                          row_end;
  logic                          frame_end;
  logic                          in_fire;
  logic                          cfg_fire;
  logic                          cfg_hit;
  logic                          s2_free;

  assign w_eff     = plyuv_pkg::eff_dim(width_r, plyuv_pkg::DIM_W'(plyuv_pkg::MAX_WIDTH));
  assign h_eff     = plyuv_pkg::eff_dim(height_r, plyuv_pkg::DIM_W'(plyuv_pkg::MAX_HEIGHT));
  assign col_max   = plyuv_pkg::XW'(w_eff - plyuv_pkg::DIM_W'(1));
  assign row_max   = plyuv_pkg::YW'((h_eff >> 1) - plyuv_pkg::DIM_W'(1));
  assign row_end   = (col_r == col_max);
  assign frame_end = row_end && (row_r == row_max);

  assign s2_free   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s2_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && (cfg_index == plyuv_pkg::REG_WIDTH ||
                                  cfg_index == plyuv_pkg::REG_HEIGHT ||
                                  cfg_index == plyuv_pkg::REG_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= plyuv_pkg::DIM_W'(1920);
      height_r <= plyuv_pkg::DIM_W'(1080);
      mode_r   <= plyuv_pkg::MODE_I420;
    end else if (cfg_fire) begin
      case (cfg_index)
        plyuv_pkg::REG_WIDTH:  width_r  <= cfg_data;
        plyuv_pkg::REG_HEIGHT: height_r <= cfg_data;
        plyuv_pkg::REG_MODE:   mode_r   <= cfg_data[plyuv_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    area_r <= w_eff * h_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      col_r <= '0;
      row_r <= '0;
      wy_r  <= '0;
      hy_r  <= '0;
    end else if (in_fire) begin
      if (frame_end) begin
        col_r <= '0;
        row_r <= '0;
        wy_r  <= '0;
        hy_r  <= '0;
      end else if (row_end) begin
        col_r <= '0;
        row_r <= row_r + plyuv_pkg::YW'(1);
        wy_r  <= wy_r + plyuv_pkg::ADDR_W'(w_eff);
        hy_r  <= hy_r + plyuv_pkg::CADDR_W'(w_eff >> 1);
      end else begin
        col_r <= col_r + plyuv_pkg::XW'(1);
      end
    end
  end

  always_comb begin
    s1_nxt.b0   = in_src_word[7:0];
    s1_nxt.b1   = in_src_word[15:8];
    s1_nxt.b2   = in_src_word[23:16];
    s1_nxt.x    = col_r;
    s1_nxt.wy   = wy_r;
    s1_nxt.hy   = hy_r;
    s1_nxt.last = frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s2_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  assign geom.w    = w_eff;
  assign geom.half = plyuv_pkg::XW'(w_eff >> 1);
  assign geom.area = area_r;
  assign geom.mode = mode_r;

  plyuv_addr u_addr (
    .geom (geom),
    .item (s1_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid_r) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_upper_luma_addr = out_r.upper_luma_addr;
  assign out_upper_luma_data = out_r.upper_luma_data;
  assign out_lower_luma_addr = out_r.lower_luma_addr;
  assign out_lower_luma_data = out_r.lower_luma_data;
  assign out_chroma_dest     = out_r.chroma_dest;
  assign out_chroma_addr     = out_r.chroma_addr;
  assign out_chroma_data     = out_r.chroma_data;
  assign out_chroma_is_v     = out_r.chroma_is_v;
  assign out_frame_last      = out_r.frame_last;

`ifndef SYNTHESIS
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_r == '0) && (row_r == '0) && (wy_r == '0) && (hy_r == '0))
    else $error("register write did not restart the frame");

  a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= col_max) && (row_r <= row_max))
    else $error("position counters outside the frame");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && frame_end && !cfg_hit) |=> (col_r == '0) && (row_r == '0) && (wy_r == '0))
    else $error("frame end did not wrap the counters");

  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_free) |=> out_valid_r)
    else $error("stage one beat lost on its way to the output");
`endif

endmodule

// ----- hdl/plyuv_addr.sv -----
module plyuv_addr (
  input  plyuv_pkg::geom_t geom,
  input  plyuv_pkg::item_t item,
  output plyuv_pkg::res_t  res
);

  logic [plyuv_pkg::MODE_W-1:0] mode;
  logic                         is_v;
  logic [plyuv_pkg::XW-1:0]     c;
  logic [plyuv_pkg::ADDR_W-1:0] w24;
  logic [plyuv_pkg::ADDR_W-1:0] x24;
  logic [plyuv_pkg::ADDR_W-1:0] c24;
  logic [plyuv_pkg::ADDR_W-1:0] hy24;
  logic [plyuv_pkg::ADDR_W-1:0] area_f;
  logic [plyuv_pkg::ADDR_W-1:0] area_h;
  logic [plyuv_pkg::ADDR_W-1:0] area_q;
  logic [plyuv_pkg::ADDR_W-1:0] wy1;
  logic [plyuv_pkg::ADDR_W-1:0] hy1;
  logic [plyuv_pkg::ADDR_W-1:0] ch24;

  assign mode   = (geom.mode > plyuv_pkg::MODE_UVYY) ? plyuv_pkg::MODE_I420 : geom.mode;
  assign is_v   = (item.x >= geom.half);
  assign c      = is_v ? item.x - geom.half : item.x;
  assign w24    = plyuv_pkg::ADDR_W'(geom.w);
  assign x24    = plyuv_pkg::ADDR_W'(item.x);
  assign c24    = plyuv_pkg::ADDR_W'(c);
  assign hy24   = plyuv_pkg::ADDR_W'(item.hy);
  assign area_f = geom.area[plyuv_pkg::ADDR_W-1:0];
  assign area_h = geom.area[plyuv_pkg::ADDR_W:1];
  assign area_q = geom.area[plyuv_pkg::ADDR_W+1:2];
  assign wy1    = item.wy + w24;
  assign hy1    = hy24 + plyuv_pkg::ADDR_W'(geom.half);

  always_comb begin
    res.lower_luma_data = item.b1;
    res.chroma_is_v     = is_v;
    res.frame_last      = item.last;
    res.upper_luma_addr = area_f - wy1 + x24;
    res.upper_luma_data = item.b0;
    res.lower_luma_addr = area_h - wy1 + x24;
    res.chroma_data     = item.b2;
    res.chroma_dest     = plyuv_pkg::DEST_SHARED;
    ch24                = (is_v ? area_h : area_q) - hy1 + c24;
    case (mode)
      plyuv_pkg::MODE_UVYY: begin
        res.upper_luma_addr = area_h + item.wy + x24;
        res.upper_luma_data = item.b2;
        res.lower_luma_addr = item.wy + x24;
        res.chroma_data     = item.b0;
        res.chroma_dest     = is_v ? plyuv_pkg::DEST_V : plyuv_pkg::DEST_U;
        ch24                = hy24 + c24;
      end
      plyuv_pkg::MODE_NV12: begin
        ch24 = area_h - wy1 + {c24[plyuv_pkg::ADDR_W-2:0], is_v};
      end
      plyuv_pkg::MODE_NV21: begin
        ch24 = area_h - wy1 + {c24[plyuv_pkg::ADDR_W-2:0], ~is_v};
      end
      plyuv_pkg::MODE_SPLIT: begin
        res.chroma_dest = is_v ? plyuv_pkg::DEST_V : plyuv_pkg::DEST_U;
        ch24            = area_q - hy1 + c24;
      end
      default: begin
        ch24 = (is_v ? area_h : area_q) - hy1 + c24;
      end
    endcase
    res.chroma_addr = ch24[plyuv_pkg::CADDR_W-1:0];
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import plyuv_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(3);
  localparam int RANDOM_WORDS = 620;

  typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [31:0]      value;
    logic             typed;
    res_t             result;
  } script_row_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [WORD_W-1:0]    in_src_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_W-1:0]    out_upper_luma_addr;
  logic [BYTE_W-1:0]    out_upper_luma_data;
  logic [ADDR_W-1:0]    out_lower_luma_addr;
  logic [BYTE_W-1:0]    out_lower_luma_data;
  logic [DEST_W-1:0]    out_chroma_dest;
  logic [CADDR_W-1:0]   out_chroma_addr;
  logic [BYTE_W-1:0]    out_chroma_data;
  logic                 out_chroma_is_v;
  logic                 out_frame_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  logic [DIM_W-1:0]     width_reg = DIM_W'(1920);
  logic [DIM_W-1:0]     height_reg = DIM_W'(1080);
  logic [MODE_W-1:0]    mode_reg = MODE_I420;
  int unsigned          col_pos = 0;
  int unsigned          row_pos = 0;
  res_t                 plane_writes_q[$];
  int                   bad_fields = 0;

  packed_luma_pair_to_planar_yuv dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_src_word         (in_src_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_upper_luma_addr (out_upper_luma_addr),
    .out_upper_luma_data (out_upper_luma_data),
    .out_lower_luma_addr (out_lower_luma_addr),
    .out_lower_luma_data (out_lower_luma_data),
    .out_chroma_dest     (out_chroma_dest),
    .out_chroma_addr     (out_chroma_addr),
    .out_chroma_data     (out_chroma_data),
    .out_chroma_is_v     (out_chroma_is_v),
    .out_frame_last      (out_frame_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("** packed_luma_pair_to_planar_yuv: FAILED **");
    $finish;
  end

  function automatic int unsigned usable_dim(logic [DIM_W-1:0] v, int unsigned cap);
    int unsigned d;
    d = 32'(v);
    if (d < 2) d = 2;
    if (d > cap) d = cap;
    return d - (d % 2);
  endfunction

  function automatic res_t next_plane_write(logic [WORD_W-1:0] word);
    int unsigned w, h, rows, half, area, x, y, c, up, lo, ca;
    logic [MODE_W-1:0] mode;
    logic is_v;
    res_t r;
    w = usable_dim(width_reg, MAX_WIDTH);
    h = usable_dim(height_reg, MAX_HEIGHT);
    rows = h / 2;
    half = w / 2;
    mode = (mode_reg > MODE_UVYY) ? MODE_I420 : mode_reg;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= rows) row_pos = 0;
    x = col_pos;
    y = row_pos;
    area = w * h;
    is_v = (x >= half);
    c = is_v ? x - half : x;
    r.lower_luma_data = word[15:8];
    r.chroma_is_v = is_v;
    if (mode == MODE_UVYY) begin
      up = area / 2 + w * y + x;
      r.upper_luma_data = word[23:16];
      lo = w * y + x;
      r.chroma_dest = is_v ? DEST_V : DEST_U;
      ca = half * y + c;
      r.chroma_data = word[7:0];
    end else begin
      up = area - w * (y + 1) + x;
      r.upper_luma_data = word[7:0];
      lo = area / 2 - w * (y + 1) + x;
      r.chroma_data = word[23:16];
      r.chroma_dest = DEST_SHARED;
      case (mode)
        MODE_NV12: ca = area / 2 - w * (y + 1) + 2 * c + (is_v ? 1 : 0);
        MODE_NV21: ca = area / 2 - w * (y + 1) + 2 * c + (is_v ? 0 : 1);
        MODE_SPLIT: begin
          r.chroma_dest = is_v ? DEST_V : DEST_U;
          ca = area / 4 - half * (y + 1) + c;
        end
        default: ca = (is_v ? area / 2 : area / 4) - half * (y + 1) + c;
      endcase
    end
    r.frame_last = (x + 1 >= w) && (y + 1 >= rows);
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= rows) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
    r.upper_luma_addr = up[ADDR_W-1:0];
    r.lower_luma_addr = lo[ADDR_W-1:0];
    r.chroma_addr = ca[CADDR_W-1:0];
    return r;
  endfunction

  function automatic res_t mk_res(int unsigned up_a, logic [7:0] up_d, int unsigned lo_a,
                                  logic [7:0] lo_d, logic [DEST_W-1:0] dest,
                                  int unsigned ch_a, logic [7:0] ch_d, logic is_v,
                                  logic last);
    res_t r;
    r.upper_luma_addr = up_a[ADDR_W-1:0];
    r.upper_luma_data = up_d;
    r.lower_luma_addr = lo_a[ADDR_W-1:0];
    r.lower_luma_data = lo_d;
    r.chroma_dest = dest;
    r.chroma_addr = ch_a[CADDR_W-1:0];
    r.chroma_data = ch_d;
    r.chroma_is_v = is_v;
    r.frame_last = last;
    return r;
  endfunction

  function automatic script_row_t reg_row(logic [IDX_W-1:0] idx, logic [31:0] value);
    script_row_t s;
    s = '0;
    s.kind = ROW_REG;
    s.idx = idx;
    s.value = value;
    return s;
  endfunction

  function automatic script_row_t word_row(logic [31:0] value, logic typed, res_t result);
    script_row_t s;
    s = '0;
    s.kind = ROW_WORD;
    s.value = value;
    s.typed = typed;
    s.result = result;
    return s;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report(string what);
    if (bad_fields < 100) $display("[%0t] mismatch: %s", $time, what);
    bad_fields++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (plane_writes_q.size() == 0) begin
        report("unexpected output beat");
      end else begin
        want = plane_writes_q.pop_front();
        check_field("upper_luma_addr", out_upper_luma_addr, want.upper_luma_addr);
        check_field("upper_luma_data", out_upper_luma_data, want.upper_luma_data);
        check_field("lower_luma_addr", out_lower_luma_addr, want.lower_luma_addr);
        check_field("lower_luma_data", out_lower_luma_data, want.lower_luma_data);
        check_field("chroma_dest", out_chroma_dest, want.chroma_dest);
        check_field("chroma_addr", out_chroma_addr, want.chroma_addr);
        check_field("chroma_data", out_chroma_data, want.chroma_data);
        check_field("chroma_is_v", out_chroma_is_v, want.chroma_is_v);
        check_field("frame_last", out_frame_last, want.frame_last);
      end
    end
  end

  // receiver: ready runs broken by stalls, now and then a long ready stretch
  initial begin
    int run, stall;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = gap_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic push_word(logic [WORD_W-1:0] word, logic typed, res_t typed_res);
    res_t r;
    cfg_valid <= 1'b0;
    in_valid <= 1'b1;
    in_src_word <= word;
    do @(posedge clk); while (!in_ready);
    r = next_plane_write(word);
    plane_writes_q.push_back(typed ? typed_res : r);
  endtask

  task automatic hold_off(int n, bit drain);
    if (n > 0 || drain) in_valid <= 1'b0;
    repeat (n) @(posedge clk);
    if (drain) while (plane_writes_q.size() != 0) @(posedge clk);
  endtask

  // registers change only with the pipe empty
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    in_valid <= 1'b0;
    while (plane_writes_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:  width_reg = data;
      REG_HEIGHT: height_reg = data;
      REG_MODE:   mode_reg = data[MODE_W-1:0];
      default: ;
    endcase
    if (idx != REG_SPARE) begin
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  initial begin
    script_row_t script_q[$];
    res_t none;
    int sent, beats, p;
    bit steady;
    none = '0;

    script_q.push_back(word_row(32'h0000_0000, 1'b1,
      mk_res(2071680, 8'h00, 1034880, 8'h00, DEST_SHARED, 517440, 8'h00, 1'b0, 1'b0)));
    script_q.push_back(word_row(32'hFFFF_FFFF, 1'b0, none));
    script_q.push_back(reg_row(REG_WIDTH, 2));
    script_q.push_back(reg_row(REG_HEIGHT, 2));
    script_q.push_back(reg_row(REG_MODE, 32'(MODE_UVYY)));
    script_q.push_back(word_row(32'h3322_1100, 1'b1,
      mk_res(2, 8'h22, 0, 8'h11, DEST_U, 0, 8'h00, 1'b0, 1'b0)));
    script_q.push_back(word_row(32'hFFEE_DDCC, 1'b1,
      mk_res(3, 8'hEE, 1, 8'hDD, DEST_V, 0, 8'hCC, 1'b1, 1'b1)));
    script_q.push_back(reg_row(REG_MODE, 32'(MODE_NV12)));
    script_q.push_back(word_row(32'h3322_1100, 1'b1,
      mk_res(2, 8'h00, 0, 8'h11, DEST_SHARED, 0, 8'h22, 1'b0, 1'b0)));
    script_q.push_back(word_row(32'hFFEE_DDCC, 1'b1,
      mk_res(3, 8'hCC, 1, 8'hDD, DEST_SHARED, 1, 8'hEE, 1'b1, 1'b1)));
    script_q.push_back(reg_row(REG_MODE, 32'(MODE_NV21)));
    script_q.push_back(word_row(32'h3322_1100, 1'b1,
      mk_res(2, 8'h00, 0, 8'h11, DEST_SHARED, 1, 8'h22, 1'b0, 1'b0)));
    script_q.push_back(word_row(32'hFFEE_DDCC, 1'b1,
      mk_res(3, 8'hCC, 1, 8'hDD, DEST_SHARED, 0, 8'hEE, 1'b1, 1'b1)));
    script_q.push_back(reg_row(REG_MODE, 32'(MODE_I420)));
    script_q.push_back(word_row(32'h3322_1100, 1'b1,
      mk_res(2, 8'h00, 0, 8'h11, DEST_SHARED, 0, 8'h22, 1'b0, 1'b0)));
    script_q.push_back(word_row(32'hFFEE_DDCC, 1'b1,
      mk_res(3, 8'hCC, 1, 8'hDD, DEST_SHARED, 1, 8'hEE, 1'b1, 1'b1)));
    script_q.push_back(reg_row(REG_MODE, 32'(MODE_SPLIT)));
    script_q.push_back(word_row(32'h3322_1100, 1'b1,
      mk_res(2, 8'h00, 0, 8'h11, DEST_U, 0, 8'h22, 1'b0, 1'b0)));
    script_q.push_back(word_row(32'hFFEE_DDCC, 1'b1,
      mk_res(3, 8'hCC, 1, 8'hDD, DEST_V, 0, 8'hEE, 1'b1, 1'b1)));
    script_q.push_back(reg_row(REG_MODE, 7));
    script_q.push_back(word_row(32'h8040_2010, 1'b0, none));
    script_q.push_back(word_row(32'h0102_0408, 1'b0, none));
    script_q.push_back(reg_row(REG_WIDTH, 4));
    script_q.push_back(reg_row(REG_MODE, 32'(MODE_I420)));
    script_q.push_back(word_row(32'hA5A5_A5A5, 1'b0, none));
    script_q.push_back(reg_row(REG_SPARE, 32'h1FFF));
    script_q.push_back(word_row(32'h5A5A_5A5A, 1'b0, none));
    script_q.push_back(word_row(32'h1234_5678, 1'b0, none));
    script_q.push_back(word_row(32'h9ABC_DEF0, 1'b0, none));
    script_q.push_back(reg_row(REG_WIDTH, 0));
    script_q.push_back(reg_row(REG_HEIGHT, 1));
    script_q.push_back(word_row(32'h7F7F_7F7F, 1'b0, none));
    script_q.push_back(word_row(32'h8080_8080, 1'b0, none));
    script_q.push_back(reg_row(REG_WIDTH, 32'h1FFF));
    script_q.push_back(reg_row(REG_HEIGHT, 32'h1FFF));
    script_q.push_back(reg_row(REG_MODE, 32'(MODE_UVYY)));
    script_q.push_back(word_row(32'hFFFF_FFFF, 1'b0, none));
    script_q.push_back(word_row(32'h0000_0000, 1'b0, none));
    script_q.push_back(reg_row(REG_WIDTH, 4095));
    script_q.push_back(reg_row(REG_MODE, 32'(MODE_I420)));
    script_q.push_back(word_row(32'hC3C3_3C3C, 1'b0, none));
    script_q.push_back(word_row(32'h3C3C_C3C3, 1'b0, none));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script_q[i]) begin
      if (script_q[i].kind == ROW_REG) begin
        write_reg(script_q[i].idx, script_q[i].value[DIM_W-1:0]);
      end else begin
        push_word(script_q[i].value, script_q[i].typed, script_q[i].result);
        hold_off(gap_len(), 1'b0);
      end
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 2) == 0) begin
        p = $urandom_range(0, 99);
        write_reg(REG_WIDTH, DIM_W'((p < 70) ? $urandom_range(0, 20) :
                                    (p < 85) ? $urandom_range(21, 200) :
                                               $urandom_range(0, 8191)));
      end
      if ($urandom_range(0, 2) == 0) begin
        p = $urandom_range(0, 99);
        write_reg(REG_HEIGHT, DIM_W'((p < 75) ? $urandom_range(0, 12) :
                                     (p < 90) ? $urandom_range(13, 64) :
                                                $urandom_range(0, 8191)));
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_MODE, DIM_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, DIM_W'($urandom_range(0, 8191)));
      steady = ($urandom_range(0, 4) == 0);
      beats = $urandom_range(20, 120);
      if (beats > RANDOM_WORDS - sent) beats = RANDOM_WORDS - sent;
      repeat (beats) begin
        push_word($urandom(), 1'b0, none);
        sent++;
        hold_off(steady ? 0 : gap_len(), $urandom_range(0, 39) == 0);
      end
    end

    hold_off(1, 1'b1);
    repeat (8) @(posedge clk);
    if (bad_fields == 0 && plane_writes_q.size() == 0) begin
      $display("** packed_luma_pair_to_planar_yuv: PASSED **");
    end else begin
      $display("** packed_luma_pair_to_planar_yuv: FAILED **");
    end
    $finish;
  end

endmodule
